FILE: sv/svv_pkg.sv
package svv_pkg;

	// Sizing
	localparam int PIXEL_BITS   = 16;
	localparam int COUNTER_BITS = 16;

	localparam int IDX_W     = PIXEL_BITS;
	localparam int BIN_W     = PIXEL_BITS + 1;
	localparam int BIN_COUNT = 1 << BIN_W;
	localparam int OFF_W     = PIXEL_BITS + 1;
	localparam int DIST_W    = PIXEL_BITS + 1;
	localparam int STEP_W    = $clog2(IDX_W);

	// Register widths, fixed by the register map
	localparam int PC_W       = 17;
	localparam int BR_W       = 17;
	localparam int REG16_W    = 16;
	localparam int CFG_DATA_W = 17;
	localparam int CFG_IDX_W  = 3;

	// Divider remainder is always below the divisor
	localparam int REM_W = BR_W;

	localparam int DCMP_W = (DIST_W > REG16_W) ? DIST_W : REG16_W;
	localparam int CCMP_W = (COUNTER_BITS > REG16_W) ? COUNTER_BITS : REG16_W;

	localparam int IN_TDATA_W  = ((IDX_W + 7) / 8) * 8;
	localparam int OUT_BITS    = OFF_W + 3;
	localparam int OUT_TDATA_W = ((OUT_BITS + 7) / 8) * 8;

	localparam int QUEUE_DEPTH = 4;
	localparam int Q_AW        = $clog2(QUEUE_DEPTH);

	// Register indexes
	localparam logic [CFG_IDX_W-1:0] REG_PIXEL_COUNT    = 3'd0;
	localparam logic [CFG_IDX_W-1:0] REG_BLOCK_ROWS     = 3'd1;
	localparam logic [CFG_IDX_W-1:0] REG_MIN_DISTANCE   = 3'd2;
	localparam logic [CFG_IDX_W-1:0] REG_VOTE_THRESHOLD = 3'd3;
	localparam logic [CFG_IDX_W-1:0] REG_MAX_REPORTS    = 3'd4;

	// Reset values
	localparam logic [PC_W-1:0]    RST_PIXEL_COUNT    = 17'd65536;
	localparam logic [BR_W-1:0]    RST_BLOCK_ROWS     = 17'd250;
	localparam logic [REG16_W-1:0] RST_MIN_DISTANCE   = 16'd16;
	localparam logic [REG16_W-1:0] RST_VOTE_THRESHOLD = 16'd128;
	localparam logic [REG16_W-1:0] RST_MAX_REPORTS    = 16'd10000;

	typedef struct packed {
		logic [PC_W-1:0]    pixel_count;
		logic [BR_W-1:0]    block_rows;
		logic [REG16_W-1:0] min_distance;
		logic [REG16_W-1:0] vote_threshold;
		logic [REG16_W-1:0] max_reports;
	} cfg_t;

	// One classified pair, front to back
	typedef struct packed {
		logic [OFF_W-1:0] offset;
		logic             direction;
		logic             vote;
		logic [BIN_W-1:0] bin;
	} pair_t;

endpackage

FILE: sv/shift_vector_voting.sv
// channel   dir  handshake            payload
// s_*       in   s_tvalid / s_tready  tdata[15:0] block_index
// m_*       out  m_tvalid / m_tready  tdata[16:0] offset, [17] direction,
//                                     [18] voted, [19] report, [23:20] zero
// cfg_*     in   cfg_valid/cfg_ready  cfg_index register, cfg_data value
//
// Front takes a new index only once the last is pushed: an accept state, a
// one-bit-per-cycle divider splitting both indices into row and column, a
// distance state and a push state that waits while the queue is full. The
// first index after reset is only stored. Back sends a pair that does not vote
// straight to the output register, a voting one through an update state for
// the histogram read-modify-write. After reset the back sweeps the 2^17-bin
// histogram to zero, one bin a cycle, with s_tready low. cfg beats are always
// taken. A stalled m_* beat holds; the queue lets the front run ahead.
module shift_vector_voting
	import svv_pkg::*;
(
	input  logic                   clk,
	input  logic                   arst_n,
	// block stream in
	input  logic                   s_tvalid,
	output logic                   s_tready,
	input  logic [IN_TDATA_W-1:0]  s_tdata,   // [15:0] block_index
	// result stream out
	output logic                   m_tvalid,
	input  logic                   m_tready,
	output logic [OUT_TDATA_W-1:0] m_tdata,   // offset, direction, voted, report
	// register writes
	input  logic                   cfg_valid,
	output logic                   cfg_ready,
	input  logic [CFG_IDX_W-1:0]   cfg_index,
	input  logic [CFG_DATA_W-1:0]  cfg_data
);

	cfg_t             cfg_q;
	logic             clearing;
	logic             push, full, pop, empty;
	pair_t            push_data, head;
	logic [OFF_W-1:0] out_offset;
	logic             out_direction, out_voted, out_report;

	// Register file, writes land at once; host must write only with nothing in flight, unchecked
	assign cfg_ready = 1'b1;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cfg_q.pixel_count    <= RST_PIXEL_COUNT;
			cfg_q.block_rows     <= RST_BLOCK_ROWS;
			cfg_q.min_distance   <= RST_MIN_DISTANCE;
			cfg_q.vote_threshold <= RST_VOTE_THRESHOLD;
			cfg_q.max_reports    <= RST_MAX_REPORTS;
		end else if (cfg_valid && cfg_ready) begin
			case (cfg_index)
				REG_PIXEL_COUNT:    cfg_q.pixel_count    <= PC_W'(cfg_data);
				REG_BLOCK_ROWS:     cfg_q.block_rows     <= BR_W'(cfg_data);
				REG_MIN_DISTANCE:   cfg_q.min_distance   <= REG16_W'(cfg_data);
				REG_VOTE_THRESHOLD: cfg_q.vote_threshold <= REG16_W'(cfg_data);
				REG_MAX_REPORTS:    cfg_q.max_reports    <= REG16_W'(cfg_data);
				default:            cfg_q                <= cfg_q;
			endcase
		end
	end

	// Front: pairing, row/column split, distance and bin
	svv_front u_front (
		.clk       (clk),
		.arst_n    (arst_n),
		.cfg       (cfg_q),
		.hold      (clearing),
		.in_valid  (s_tvalid),
		.in_ready  (s_tready),
		.in_index  (s_tdata[IDX_W-1:0]),
		.push      (push),
		.push_data (push_data),
		.full      (full)
	);

	// Short queue of classified pairs
	svv_queue u_queue (
		.clk       (clk),
		.arst_n    (arst_n),
		.push      (push),
		.push_data (push_data),
		.full      (full),
		.pop       (pop),
		.head      (head),
		.empty     (empty)
	);

	// Back: histogram update, report limit, output register
	svv_back u_back (
		.clk           (clk),
		.arst_n        (arst_n),
		.cfg           (cfg_q),
		.empty         (empty),
		.head          (head),
		.pop           (pop),
		.clearing      (clearing),
		.out_valid     (m_tvalid),
		.out_ready     (m_tready),
		.out_offset    (out_offset),
		.out_direction (out_direction),
		.out_voted     (out_voted),
		.out_report    (out_report)
	);

	assign m_tdata = OUT_TDATA_W'({out_report, out_voted, out_direction, out_offset});

endmodule

FILE: sv/svv_front.sv
module svv_front
	import svv_pkg::*;
(
	input  logic             clk,
	input  logic             arst_n,
	input  cfg_t             cfg,
	input  logic             hold,
	input  logic             in_valid,
	output logic             in_ready,
	input  logic [IDX_W-1:0] in_index,
	output logic             push,
	output pair_t            push_data,
	input  logic             full
);

	typedef enum logic [1:0] {F_IDLE, F_DIV, F_DIST, F_PUSH} fstate_t;

	localparam logic [STEP_W-1:0] STEP_LAST = STEP_W'(IDX_W - 1);

	fstate_t           state_q;
	logic [IDX_W-1:0]  prev_q;
	logic              have_prev_q;
	logic [IDX_W-1:0]  hi_q, lo_q;       // dividend in, quotient out
	logic [REM_W-1:0]  rhi_q, rlo_q;
	logic [BR_W-1:0]   div_q;
	logic [STEP_W-1:0] step_q;
	logic              dir_q;
	logic [IDX_W-1:0]  diff_q;
	logic [IDX_W-1:0]  rowdiff_q, coldiff_q;
	logic [OFF_W-1:0]  offset_q;
	logic [BIN_W-1:0]  bin_q;

	logic [REM_W:0]    trial_hi, trial_lo, sub_hi, sub_lo;
	logic              ge_hi, ge_lo;
	logic              neg;
	logic [OFF_W-1:0]  diff_ext;
	logic [DIST_W-1:0] manhattan;
	logic              vote;

	// One quotient bit per cycle on both indices
	always_comb begin
		trial_hi = {rhi_q, hi_q[IDX_W-1]};
		trial_lo = {rlo_q, lo_q[IDX_W-1]};
		ge_hi    = trial_hi >= {1'b0, div_q};
		ge_lo    = trial_lo >= {1'b0, div_q};
		sub_hi   = trial_hi - {1'b0, div_q};
		sub_lo   = trial_lo - {1'b0, div_q};
	end

	assign neg       = rhi_q < rlo_q;
	assign diff_ext  = OFF_W'(diff_q);
	assign manhattan = DIST_W'(rowdiff_q) + DIST_W'(coldiff_q);
	assign vote      = DCMP_W'(manhattan) > DCMP_W'(cfg.min_distance);

	assign in_ready  = (state_q == F_IDLE) && !hold;
	assign push      = (state_q == F_PUSH) && !full;
	assign push_data = '{offset: offset_q, direction: dir_q, vote: vote, bin: bin_q};

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q     <= F_IDLE;
			prev_q      <= '0;
			have_prev_q <= 1'b0;
		end else begin
			case (state_q)
				F_IDLE: begin
					if (in_valid && in_ready) begin
						prev_q      <= in_index;
						have_prev_q <= 1'b1;
						if (have_prev_q) begin
							if (in_index > prev_q) begin
								hi_q   <= in_index;
								lo_q   <= prev_q;
								dir_q  <= 1'b0;
								diff_q <= in_index - prev_q;
							end else begin
								hi_q   <= prev_q;
								lo_q   <= in_index;
								dir_q  <= 1'b1;
								diff_q <= prev_q - in_index;
							end
							rhi_q   <= '0;
							rlo_q   <= '0;
							div_q   <= (cfg.block_rows == '0) ? BR_W'(1) : cfg.block_rows;
							step_q  <= STEP_LAST;
							state_q <= F_DIV;
						end
					end
				end
				F_DIV: begin
					rhi_q  <= ge_hi ? sub_hi[REM_W-1:0] : trial_hi[REM_W-1:0];
					rlo_q  <= ge_lo ? sub_lo[REM_W-1:0] : trial_lo[REM_W-1:0];
					hi_q   <= {hi_q[IDX_W-2:0], ge_hi};
					lo_q   <= {lo_q[IDX_W-2:0], ge_lo};
					step_q <= step_q - 1'b1;
					if (step_q == '0) begin
						state_q <= F_DIST;
					end
				end
				F_DIST: begin
					// rows in rhi_q/rlo_q, columns in hi_q/lo_q
					rowdiff_q <= neg ? IDX_W'(rlo_q - rhi_q) : IDX_W'(rhi_q - rlo_q);
					coldiff_q <= hi_q - lo_q;
					offset_q  <= neg ? OFF_W'('0) - diff_ext : diff_ext;
					bin_q     <= neg ? BIN_W'(cfg.pixel_count) - 1'b1 + BIN_W'(diff_q)
					                 : BIN_W'(diff_q);
					state_q   <= F_PUSH;
				end
				F_PUSH: begin
					if (!full) begin
						state_q <= F_IDLE;
					end
				end
				default: state_q <= F_IDLE;
			endcase
		end
	end

endmodule

FILE: sv/svv_queue.sv
module svv_queue
	import svv_pkg::*;
(
	input  logic  clk,
	input  logic  arst_n,
	input  logic  push,
	input  pair_t push_data,
	output logic  full,
	input  logic  pop,
	output pair_t head,
	output logic  empty
);

	pair_t           slot_q [QUEUE_DEPTH];
	logic [Q_AW-1:0] wr_q, rd_q;
	logic [Q_AW:0]   count_q;

	assign full  = count_q == (Q_AW+1)'(QUEUE_DEPTH);
	assign empty = count_q == '0;
	assign head  = slot_q[rd_q];

	always_ff @(posedge clk) begin
		if (push) begin
			slot_q[wr_q] <= push_data;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_q    <= '0;
			rd_q    <= '0;
			count_q <= '0;
		end else begin
			if (push) begin
				wr_q <= wr_q + 1'b1;
			end
			if (pop) begin
				rd_q <= rd_q + 1'b1;
			end
			case ({push, pop})
				2'b10:   count_q <= count_q + 1'b1;
				2'b01:   count_q <= count_q - 1'b1;
				default: count_q <= count_q;
			endcase
		end
	end

endmodule

FILE: sv/svv_back.sv
module svv_back
	import svv_pkg::*;
(
	input  logic             clk,
	input  logic             arst_n,
	input  cfg_t             cfg,
	input  logic             empty,
	input  pair_t            head,
	output logic             pop,
	output logic             clearing,
	output logic             out_valid,
	input  logic             out_ready,
	output logic [OFF_W-1:0] out_offset,
	output logic             out_direction,
	output logic             out_voted,
	output logic             out_report
);

	typedef enum logic [1:0] {B_CLEAR, B_IDLE, B_UPD} bstate_t;

	localparam logic [COUNTER_BITS-1:0] COUNT_MAX = '1;

	logic [COUNTER_BITS-1:0] hist_mem [BIN_COUNT];

	bstate_t                 state_q;
	logic [BIN_W-1:0]        clr_q;
	pair_t                   cur_q;
	logic [REG16_W-1:0]      reports_q;
	logic [COUNTER_BITS-1:0] rdata_q;
	logic                    valid_q;
	logic [OFF_W-1:0]        offset_q;
	logic                    dir_q, voted_q, report_q;

	logic                    we;
	logic [BIN_W-1:0]        waddr;
	logic [COUNTER_BITS-1:0] wdata;
	logic [COUNTER_BITS-1:0] cnt_inc;
	logic                    report;

	assign cnt_inc = (rdata_q == COUNT_MAX) ? rdata_q : rdata_q + 1'b1;
	assign report  = (CCMP_W'(cnt_inc) > CCMP_W'(cfg.vote_threshold))
	                 && (reports_q < cfg.max_reports);

	assign clearing = state_q == B_CLEAR;
	assign pop      = (state_q == B_IDLE) && !empty && !valid_q;

	always_comb begin
		we    = 1'b0;
		waddr = cur_q.bin;
		wdata = cnt_inc;
		case (state_q)
			B_CLEAR: begin
				we    = 1'b1;
				waddr = clr_q;
				wdata = '0;
			end
			B_UPD:   we = 1'b1;
			default: we = 1'b0;
		endcase
	end

	always_ff @(posedge clk) begin
		if (we) begin
			hist_mem[waddr] <= wdata;
		end
		rdata_q <= hist_mem[head.bin];
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q   <= B_CLEAR;
			clr_q     <= '0;
			reports_q <= '0;
			valid_q   <= 1'b0;
		end else begin
			if (valid_q && out_ready) begin
				valid_q <= 1'b0;
			end
			case (state_q)
				B_CLEAR: begin
					clr_q <= clr_q + 1'b1;
					if (clr_q == '1) begin
						state_q <= B_IDLE;
					end
				end
				B_IDLE: begin
					if (pop) begin
						cur_q <= head;
						if (head.vote) begin
							state_q <= B_UPD;
						end else begin
							valid_q  <= 1'b1;
							offset_q <= head.offset;
							dir_q    <= head.direction;
							voted_q  <= 1'b0;
							report_q <= 1'b0;
						end
					end
				end
				B_UPD: begin
					valid_q  <= 1'b1;
					offset_q <= cur_q.offset;
					dir_q    <= cur_q.direction;
					voted_q  <= 1'b1;
					report_q <= report;
					if (report) begin
						reports_q <= reports_q + 1'b1;
					end
					state_q <= B_IDLE;
				end
				default: state_q <= B_IDLE;
			endcase
		end
	end

	assign out_valid     = valid_q;
	assign out_offset    = offset_q;
	assign out_direction = dir_q;
	assign out_voted     = voted_q;
	assign out_report    = report_q;

endmodule

FILE: sv/svv_checker.sv
module svv_checker
	import svv_pkg::*;
(
	input logic                   clk,
	input logic                   arst_n,
	input logic                   m_tvalid,
	input logic                   m_tready,
	input logic [OUT_TDATA_W-1:0] m_tdata
);

	localparam int DIR_BIT    = OFF_W;
	localparam int VOTED_BIT  = OFF_W + 1;
	localparam int REPORT_BIT = OFF_W + 2;

	// stalled beat stays
	a_hold_valid: assert property (@(posedge clk) disable iff (!arst_n)
		m_tvalid && !m_tready |=> m_tvalid)
		else $error("result beat dropped while stalled");

	a_hold_data: assert property (@(posedge clk) disable iff (!arst_n)
		m_tvalid && !m_tready |=> $stable(m_tdata))
		else $error("result beat changed while stalled");

	// a report only comes from a vote
	a_report_voted: assert property (@(posedge clk) disable iff (!arst_n)
		m_tvalid && m_tdata[REPORT_BIT] |-> m_tdata[VOTED_BIT])
		else $error("report without vote");

	// equal indices: direction set, distance zero so no vote
	a_zero_offset: assert property (@(posedge clk) disable iff (!arst_n)
		m_tvalid && (m_tdata[OFF_W-1:0] == '0) |-> m_tdata[DIR_BIT] && !m_tdata[VOTED_BIT])
		else $error("zero offset with wrong direction or vote");

endmodule

bind shift_vector_voting svv_checker u_svv_checker (
	.clk      (clk),
	.arst_n   (arst_n),
	.m_tvalid (m_tvalid),
	.m_tready (m_tready),
	.m_tdata  (m_tdata)
);

FILE: dv/shift_vector_voting_test.sv
module shift_vector_voting_test;
	timeunit 1ns;
	timeprecision 1ps;
	import svv_pkg::*;

	// Cycles of quiet allowed after the last expected result before registers change
	// or the run ends: covers the front pass plus the histogram update, and an
	// unpaired first index that never produces a result.
	localparam int SETTLE_CYCLES = 48;
	// Idle cycles tolerated before declaring a hang. The input side stays closed
	// for the whole post-reset histogram sweep.
	localparam int IDLE_LIMIT = 600000;
	localparam int RANDOM_BEATS = 2000;
	localparam int PHASES = 8;
	localparam int unsigned COUNT_MAX = 32'((64'd1 << COUNTER_BITS) - 1);

	// Register indexes past the map; writes there must change nothing
	localparam logic [CFG_IDX_W-1:0] REG_UNMAPPED = 3'd7;
	localparam logic [CFG_IDX_W-1:0] REG_FIRST_UNUSED = 3'd5;

	typedef struct packed {
		logic [OFF_W-1:0] offset;
		logic             direction;
		logic             voted;
		logic             report;
	} verdict_t;

	typedef enum logic [1:0] {STEP_REG, STEP_INDEX, STEP_CHECKED} step_kind_t;

	typedef struct packed {
		step_kind_t             kind;
		logic [CFG_IDX_W-1:0]   reg_sel;
		logic [CFG_DATA_W-1:0]  value;
		logic [IDX_W-1:0]       index;
		verdict_t               want;
	} step_t;

	logic                   clk;
	logic                   arst_n;
	logic                   s_tvalid;
	logic                   s_tready;
	logic [IN_TDATA_W-1:0]  s_tdata;   // [15:0] block_index
	logic                   m_tvalid;
	logic                   m_tready;
	logic [OUT_TDATA_W-1:0] m_tdata;   // [16:0] offset, [17] direction, [18] voted, [19] report
	logic                   cfg_valid;
	logic                   cfg_ready;
	logic [CFG_IDX_W-1:0]   cfg_index;
	logic [CFG_DATA_W-1:0]  cfg_data;

	shift_vector_voting u_top (
		.clk       (clk),
		.arst_n    (arst_n),
		.s_tvalid  (s_tvalid),
		.s_tready  (s_tready),
		.s_tdata   (s_tdata),
		.m_tvalid  (m_tvalid),
		.m_tready  (m_tready),
		.m_tdata   (m_tdata),
		.cfg_valid (cfg_valid),
		.cfg_ready (cfg_ready),
		.cfg_index (cfg_index),
		.cfg_data  (cfg_data)
	);

	// Shadow of the register file, as the block should hold it
	int unsigned pixels_cfg = 32'(RST_PIXEL_COUNT);
	int unsigned rows_cfg = 32'(RST_BLOCK_ROWS);
	int unsigned min_dist_cfg = 32'(RST_MIN_DISTANCE);
	int unsigned threshold_cfg = 32'(RST_VOTE_THRESHOLD);
	int unsigned report_cap_cfg = 32'(RST_MAX_REPORTS);

	// Shadow of the pairing and voting state
	logic [IDX_W-1:0] last_index = '0;
	bit               have_last = 1'b0;
	int unsigned      bin_votes [BIN_COUNT];
	int unsigned      reports_raised = 0;

	verdict_t pending_verdicts[$];
	step_t    plan[$];
	int       mismatches = 0;
	int       idle_cycles = 0;
	bit       sender_gaps = 1'b1;

	initial begin
		clk = 1'b0;
		forever #5 clk = ~clk;
	end

	// Pair the incoming index with the previous one and vote, as the block does.
	// Returns 0 for the very first index, which only primes the pairing.
	function automatic bit vote_pair(input logic [IDX_W-1:0] cur, output verdict_t v);
		int unsigned hi, lo, div, row_hi, row_lo, col_hi, col_lo, span, diff, bin;
		bit negative;
		v = '0;
		if (!have_last) begin
			have_last = 1'b1;
			last_index = cur;
			return 1'b0;
		end
		if (cur > last_index) begin
			hi = 32'(cur);
			lo = 32'(last_index);
		end else begin
			hi = 32'(last_index);
			lo = 32'(cur);
			v.direction = 1'b1;
		end
		last_index = cur;
		// zero rows behaves as a single row
		div = (rows_cfg == 0) ? 1 : rows_cfg;
		row_hi = hi % div;
		col_hi = hi / div;
		row_lo = lo % div;
		col_lo = lo / div;
		span = ((row_hi >= row_lo) ? row_hi - row_lo : row_lo - row_hi) + (col_hi - col_lo);
		diff = hi - lo;
		negative = row_hi < row_lo;
		v.offset = negative ? OFF_W'(0 - diff) : OFF_W'(diff);
		if (span > min_dist_cfg) begin
			v.voted = 1'b1;
			// negative bins sit above pixel_count - 1; anything past the store wraps
			bin = negative ? pixels_cfg - 1 + diff : diff;
			bin = bin & (BIN_COUNT - 1);
			if (bin_votes[bin] < COUNT_MAX)
				bin_votes[bin]++;
			if (bin_votes[bin] > threshold_cfg && reports_raised < report_cap_cfg) begin
				v.report = 1'b1;
				reports_raised++;
			end
		end
		return 1'b1;
	endfunction

	function automatic void apply_setting(input logic [CFG_IDX_W-1:0] sel,
			input logic [CFG_DATA_W-1:0] value);
		case (sel)
		REG_PIXEL_COUNT:    pixels_cfg = 32'(value[PC_W-1:0]);
		REG_BLOCK_ROWS:     rows_cfg = 32'(value[BR_W-1:0]);
		REG_MIN_DISTANCE:   min_dist_cfg = 32'(value[REG16_W-1:0]);
		REG_VOTE_THRESHOLD: threshold_cfg = 32'(value[REG16_W-1:0]);
		REG_MAX_REPORTS:    report_cap_cfg = 32'(value[REG16_W-1:0]);
		default: ;
		endcase
	endfunction

	// Mostly short gaps, now and then a long one
	function automatic int unsigned pick_gap();
		int unsigned roll;
		roll = $urandom_range(0, 99);
		if (roll < 45)
			return 0;
		if (roll < 85)
			return $urandom_range(1, 3);
		if (roll < 97)
			return $urandom_range(4, 12);
		return $urandom_range(20, 80);
	endfunction

	task automatic flag_mismatch(input string what, input int unsigned got,
			input int unsigned want);
		$display("%0t: %s mismatch, got %0h expected %0h", $time, what, got, want);
		mismatches++;
	endtask

	// One index beat. tvalid is left high so a back-to-back beat keeps it up;
	// a gap or a drain lowers it. A typed expectation replaces the predicted one,
	// though the shadow state still advances.
	task automatic send_index(input logic [IDX_W-1:0] idx, input bit typed = 1'b0,
			input verdict_t typed_want = '0);
		int unsigned gap;
		verdict_t v;
		gap = sender_gaps ? pick_gap() : 0;
		if (gap > 0) begin
			s_tvalid <= 1'b0;
			repeat (gap) @(posedge clk);
		end
		s_tvalid <= 1'b1;
		s_tdata <= idx;
		do @(posedge clk); while (!s_tready);
		if (vote_pair(idx, v)) begin
			if (typed)
				v = typed_want;
			pending_verdicts = {pending_verdicts, v};
		end
	endtask

	// Stop sending, let every expected result arrive, then let the pipe go quiet
	task automatic drain();
		s_tvalid <= 1'b0;
		@(posedge clk);
		while (pending_verdicts.size() != 0) @(posedge clk);
		repeat (SETTLE_CYCLES) @(posedge clk);
	endtask

	task automatic write_reg(input logic [CFG_IDX_W-1:0] sel,
			input logic [CFG_DATA_W-1:0] value);
		cfg_valid <= 1'b1;
		cfg_index <= sel;
		cfg_data <= value;
		do @(posedge clk); while (!cfg_ready);
		cfg_valid <= 1'b0;
		apply_setting(sel, value);
		@(posedge clk);
	endtask

	// Fresh register set for a random phase, extremes weighted in
	task automatic pick_settings();
		case ($urandom_range(0, 4))
		0: write_reg(REG_PIXEL_COUNT, 17'd65536);
		1: write_reg(REG_PIXEL_COUNT, 17'd0);
		2: write_reg(REG_PIXEL_COUNT, 17'd1);
		3: write_reg(REG_PIXEL_COUNT, 17'h1FFFF);
		default: write_reg(REG_PIXEL_COUNT, CFG_DATA_W'($urandom_range(1, 65536)));
		endcase
		case ($urandom_range(0, 7))
		0: write_reg(REG_BLOCK_ROWS, 17'd0);
		1: write_reg(REG_BLOCK_ROWS, 17'd1);
		2: write_reg(REG_BLOCK_ROWS, 17'd65536);
		3: write_reg(REG_BLOCK_ROWS, 17'h1FFFF);
		4: write_reg(REG_BLOCK_ROWS, 17'd250);
		default: write_reg(REG_BLOCK_ROWS, CFG_DATA_W'($urandom_range(2, 400)));
		endcase
		case ($urandom_range(0, 4))
		0: write_reg(REG_MIN_DISTANCE, 17'd0);
		1: write_reg(REG_MIN_DISTANCE, 17'hFFFF);
		2: write_reg(REG_MIN_DISTANCE, CFG_DATA_W'($urandom_range(0, 65535)));
		default: write_reg(REG_MIN_DISTANCE, CFG_DATA_W'($urandom_range(0, 40)));
		endcase
		case ($urandom_range(0, 4))
		0: write_reg(REG_VOTE_THRESHOLD, 17'd0);
		1: write_reg(REG_VOTE_THRESHOLD, 17'hFFFF);
		2: write_reg(REG_VOTE_THRESHOLD, CFG_DATA_W'($urandom_range(0, 65535)));
		default: write_reg(REG_VOTE_THRESHOLD, CFG_DATA_W'($urandom_range(0, 12)));
		endcase
		case ($urandom_range(0, 4))
		0: write_reg(REG_MAX_REPORTS, 17'd0);
		1: write_reg(REG_MAX_REPORTS, 17'hFFFF);
		2: write_reg(REG_MAX_REPORTS, CFG_DATA_W'($urandom_range(0, 65535)));
		default: write_reg(REG_MAX_REPORTS, CFG_DATA_W'($urandom_range(0, 30)));
		endcase
		if ($urandom_range(0, 3) == 0)
			write_reg(CFG_IDX_W'($urandom_range(REG_FIRST_UNUSED, REG_UNMAPPED)),
				CFG_DATA_W'($urandom_range(0, 17'h1FFFF)));
	endtask

	function automatic step_t reg_step(input logic [CFG_IDX_W-1:0] sel,
			input logic [CFG_DATA_W-1:0] value);
		step_t s;
		s = '0;
		s.kind = STEP_REG;
		s.reg_sel = sel;
		s.value = value;
		return s;
	endfunction

	function automatic step_t index_step(input logic [IDX_W-1:0] idx);
		step_t s;
		s = '0;
		s.kind = STEP_INDEX;
		s.index = idx;
		return s;
	endfunction

	function automatic step_t checked_step(input logic [IDX_W-1:0] idx,
			input logic [OFF_W-1:0] offset, input bit direction, input bit voted,
			input bit report);
		step_t s;
		s = '0;
		s.kind = STEP_CHECKED;
		s.index = idx;
		s.want = '{offset: offset, direction: direction, voted: voted, report: report};
		return s;
	endfunction

	function automatic void add_step(input step_t s);
		plan = {plan, s};
	endfunction

	// Stimulus: directed table first, then random phases with their own settings
	initial begin
		bit busy;
		int unsigned shifts[3];
		int unsigned sent, roll;
		logic [IDX_W-1:0] base, partner;

		arst_n = 1'b0;
		s_tvalid = 1'b0;
		s_tdata = '0;
		cfg_valid = 1'b0;
		cfg_index = '0;
		cfg_data = '0;
		repeat (7) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		// Reset settings: 250 rows, distance 16, threshold 128
		add_step(index_step(16'd0));                           // first index only primes
		add_step(checked_step(16'd0, 17'd0, 1'b1, 1'b0, 1'b0)); // equal pair
		add_step(checked_step(16'hFFFF, 17'h0FFFF, 1'b0, 1'b1, 1'b0));
		add_step(checked_step(16'd0, 17'h0FFFF, 1'b1, 1'b1, 1'b0));
		add_step(index_step(16'hFFFF));
		// zero rows acts as one row: every index is a column
		add_step(reg_step(REG_BLOCK_ROWS, 17'd0));
		add_step(index_step(16'd1));
		add_step(index_step(16'd1));
		// 7 rows: 8 sits in row 1, 6 in row 6, so the offset goes negative
		add_step(reg_step(REG_BLOCK_ROWS, 17'd7));
		add_step(reg_step(REG_MIN_DISTANCE, 17'd0));
		add_step(index_step(16'd6));
		add_step(index_step(16'd8));
		// pixel count zero: the negative bin base wraps around the store
		add_step(reg_step(REG_PIXEL_COUNT, 17'd0));
		add_step(index_step(16'd6));
		add_step(index_step(16'd8));
		// every vote reports until the cap of two is used up
		add_step(reg_step(REG_PIXEL_COUNT, 17'd1));
		add_step(reg_step(REG_VOTE_THRESHOLD, 17'd0));
		add_step(reg_step(REG_MAX_REPORTS, 17'd2));
		add_step(index_step(16'd100));
		add_step(index_step(16'd3000));
		add_step(index_step(16'd100));
		add_step(index_step(16'd3000));
		// rows wider than any index: row is the index, column zero
		add_step(reg_step(REG_BLOCK_ROWS, 17'd65536));
		add_step(reg_step(REG_MIN_DISTANCE, 17'hFFFF));
		add_step(index_step(16'd0));
		add_step(index_step(16'hFFFF));
		add_step(reg_step(REG_BLOCK_ROWS, 17'h1FFFF));
		add_step(reg_step(REG_MIN_DISTANCE, 17'd0));
		add_step(index_step(16'h5555));
		add_step(index_step(16'h5555));
		add_step(reg_step(REG_VOTE_THRESHOLD, 17'hFFFF));
		add_step(reg_step(REG_MAX_REPORTS, 17'hFFFF));
		add_step(reg_step(REG_PIXEL_COUNT, 17'h1FFFF));
		add_step(reg_step(REG_UNMAPPED, 17'h1FFFF));
		add_step(index_step(16'hAAAA));
		add_step(index_step(16'h5555));

		busy = 1'b0;
		foreach (plan[i]) begin
			if (plan[i].kind == STEP_REG) begin
				// registers change only with the pipe empty
				if (busy)
					drain();
				busy = 1'b0;
				write_reg(plan[i].reg_sel, plan[i].value);
			end else begin
				send_index(plan[i].index, plan[i].kind == STEP_CHECKED, plan[i].want);
				busy = 1'b1;
			end
		end

		// Random phases. Copied regions show up as index pairs a fixed shift apart,
		// so most beats come as such pairs to pile votes into a few bins.
		for (int ph = 0; ph < PHASES; ph++) begin
			drain();
			pick_settings();
			sender_gaps = ($urandom_range(0, 3) != 0);
			foreach (shifts[k])
				shifts[k] = $urandom_range(0, 1) ? $urandom_range(1, 600)
					: rows_cfg * $urandom_range(1, 8) + $urandom_range(0, 3);
			sent = 0;
			while (sent < RANDOM_BEATS / PHASES) begin
				// now and then hold off until the block has caught up completely
				if ($urandom_range(0, 199) == 0)
					drain();
				roll = $urandom_range(0, 99);
				if (roll < 60) begin
					base = IDX_W'($urandom_range(0, 65535));
					partner = base + IDX_W'(shifts[$urandom_range(0, 2)]);
					if ($urandom_range(0, 1)) begin
						send_index(base);
						send_index(partner);
					end else begin
						send_index(partner);
						send_index(base);
					end
					sent += 2;
				end else begin
					if (roll < 70)
						send_index(last_index);
					else if (roll < 78)
						send_index($urandom_range(0, 1) ? 16'hFFFF : 16'h0000);
					else
						send_index(IDX_W'($urandom_range(0, 65535)));
					sent++;
				end
			end
		end

		drain();
		if (mismatches == 0)
			$display("shift_vector_voting_test OK");
		else
			$display("shift_vector_voting_test NOT OK");
		$finish;
	end

	// Result side: ready in runs, long unbroken runs mixed with stalls
	initial begin
		int unsigned run, pause;
		m_tready = 1'b0;
		forever begin
			run = ($urandom_range(0, 7) == 0) ? $urandom_range(60, 400) : $urandom_range(1, 16);
			m_tready <= 1'b1;
			repeat (run) @(posedge clk);
			pause = pick_gap();
			m_tready <= 1'b0;
			repeat (pause + 1) @(posedge clk);
		end
	end

	// Every accepted result beat against the oldest outstanding expectation
	always @(posedge clk) begin : check_results
		verdict_t got, want;
		if (arst_n && m_tvalid && m_tready) begin
			got.offset = m_tdata[OFF_W-1:0];
			got.direction = m_tdata[OFF_W];
			got.voted = m_tdata[OFF_W+1];
			got.report = m_tdata[OFF_W+2];
			if (pending_verdicts.size() == 0) begin
				flag_mismatch("unexpected result beat", 32'(m_tdata), 0);
			end else begin
				want = pending_verdicts.pop_front();
				if (got.offset !== want.offset)
					flag_mismatch("offset", 32'(got.offset), 32'(want.offset));
				if (got.direction !== want.direction)
					flag_mismatch("direction", 32'(got.direction), 32'(want.direction));
				if (got.voted !== want.voted)
					flag_mismatch("voted", 32'(got.voted), 32'(want.voted));
				if (got.report !== want.report)
					flag_mismatch("report", 32'(got.report), 32'(want.report));
			end
		end
	end

	// Hang detection: no beat on any channel for too long
	always @(posedge clk) begin
		if ((s_tvalid && s_tready) || (m_tvalid && m_tready) || (cfg_valid && cfg_ready)) begin
			idle_cycles <= 0;
		end else if (idle_cycles >= IDLE_LIMIT) begin
			$display("%0t: no beat for %0d cycles, %0d results outstanding", $time,
				idle_cycles, pending_verdicts.size());
			$display("shift_vector_voting_test NOT OK");
			$finish;
		end else begin
			idle_cycles <= idle_cycles + 1;
		end
	end

endmodule
